// File: design/deq_pkg.sv
// Package for the double-ended queue: sizes, operation and status codes,
// and the request and response payload structs.
// Depends on nothing; used by design/double_ended_queue.sv.
`default_nettype none

package deq_pkg;

   // Ring size. Pointer arithmetic wraps by truncation, so DEPTH is a power of two.
   localparam int DEPTH   = 16;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] value;
      logic [ADDR_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data_out;
      logic [COUNT_W-1:0] entry_count;
      logic [STAT_W-1:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/double_ended_queue.sv
// Path: an accepted request is held in stage 1 (with the slot RAM read), then in the out reg.
// Throughput: one request per cycle; the front pointer and fill count update at accept,
// so the next request sees them at once, and the slot RAM's single port serves one
// request per cycle. Backpressure on the response side stalls requests.
// Reset: front pointer and fill count clear to zero; slot contents are not cleared.
// Depends on design/deq_pkg.sv.
`default_nettype none

module double_ended_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire deq_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      deq_pkg::rsp_type rsp_data
);

   // Ring state: front pointer and entry count live in flops, the words in the slot RAM.
   logic [deq_pkg::ADDR_W-1:0]  front_ff, front_in;
   logic [deq_pkg::COUNT_W-1:0] fill_ff, fill_in;

   // Slot RAM: one port, synchronous write, registered read.
   logic [deq_pkg::DATA_W-1:0] slots_ff [deq_pkg::DEPTH];
   logic [deq_pkg::DATA_W-1:0] rd_data_ff;
   logic                       mem_we, mem_re;
   logic [deq_pkg::ADDR_W-1:0] mem_addr;

   // Stage 1: request waits for its RAM read data.
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_read_ff;
   logic [deq_pkg::COUNT_W-1:0] s1_count_ff;
   logic [deq_pkg::STAT_W-1:0]  s1_status_ff;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type rsp_ff;

   logic                        req_accept, s1_advance;
   logic [deq_pkg::STAT_W-1:0]  status;
   logic [deq_pkg::ADDR_W-1:0]  back_next;   // slot just past the back entry
   logic                        is_empty, is_full, out_of_range;

   // Move stage 1 forward whenever the output register is free or being drained.
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   assign back_next    = front_ff + fill_ff[deq_pkg::ADDR_W-1:0];
   assign is_empty     = (fill_ff == '0);
   assign is_full      = (fill_ff == deq_pkg::COUNT_FULL);
   assign out_of_range = ({1'b0, req_data.position} >= fill_ff);

   // Decode the request: pick the RAM access and the new ring state.
   always_comb begin
      front_in = front_ff;
      fill_in  = fill_ff;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = '0;
      status   = deq_pkg::STAT_OK;
      case (req_data.mode)
         deq_pkg::MODE_PUSH_FRONT: begin
            if (is_full) begin
               status = deq_pkg::STAT_FULL;
            end else begin
               mem_addr = front_ff - 1'b1;
               mem_we   = 1'b1;
               front_in = front_ff - 1'b1;
               fill_in  = fill_ff + 1'b1;
            end
         end
         deq_pkg::MODE_PUSH_BACK: begin
            if (is_full) begin
               status = deq_pkg::STAT_FULL;
            end else begin
               mem_addr = back_next;
               mem_we   = 1'b1;
               fill_in  = fill_ff + 1'b1;
            end
         end
         deq_pkg::MODE_POP_FRONT: begin
            if (is_empty) begin
               status = deq_pkg::STAT_EMPTY;
            end else begin
               mem_addr = front_ff;
               mem_re   = 1'b1;
               front_in = front_ff + 1'b1;
               fill_in  = fill_ff - 1'b1;
            end
         end
         deq_pkg::MODE_POP_BACK: begin
            if (is_empty) begin
               status = deq_pkg::STAT_EMPTY;
            end else begin
               mem_addr = back_next - 1'b1;
               mem_re   = 1'b1;
               fill_in  = fill_ff - 1'b1;
            end
         end
         deq_pkg::MODE_READ: begin
            if (out_of_range) begin
               status = deq_pkg::STAT_RANGE;
            end else begin
               mem_addr = front_ff + req_data.position;
               mem_re   = 1'b1;
            end
         end
         default: begin
            // Unknown mode: no operation, report the current count.
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   // Slot RAM. A write at one edge is visible to a read at the next edge, and one
   // request never both writes and reads, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (req_accept && mem_we) begin
         slots_ff[mem_addr] <= req_data.value;
      end
      if (req_accept && mem_re) begin
         rd_data_ff <= slots_ff[mem_addr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            front_ff <= front_in;
            fill_ff  <= fill_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture at accept, then hand to the output register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_read_ff   <= mem_re;
         s1_count_ff  <= fill_in;
         s1_status_ff <= status;
      end
      if (s1_valid_ff && s1_advance) begin
         rsp_ff.data_out    <= s1_read_ff ? rd_data_ff : '0;
         rsp_ff.entry_count <= s1_count_ff;
         rsp_ff.status      <= s1_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= deq_pkg::COUNT_FULL)
      else $error("fill count exceeds depth");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && s1_valid_ff) |-> req_stall)
      else $error("request accepted with both stages blocked");

   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == deq_pkg::STAT_EMPTY)
         |-> (rsp_ff.entry_count == '0 && rsp_ff.data_out == '0))
      else $error("empty status with nonzero count or data");

   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == deq_pkg::STAT_FULL)
         |-> (rsp_ff.entry_count == deq_pkg::COUNT_FULL && rsp_ff.data_out == '0))
      else $error("full status with wrong count or nonzero data");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Testbench for double_ended_queue: a directed table and then random runs of
// requests, each response checked against a golden value from the table or an in-bench model of the deque.
// Depends on design/deq_pkg.sv and design/double_ended_queue.sv.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Modes above MODE_READ do nothing; this one names the top of that range.
   localparam logic [deq_pkg::MODE_W-1:0] MODE_NONE = {deq_pkg::MODE_W{1'b1}};

   localparam int RANDOM_REQUESTS = 1320;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int DRAIN_CYCLES    = 8;

   typedef enum {RUN_PUSH, RUN_POP, RUN_READ, RUN_MIXED} run_kind_type;

   // One row of the directed table. Rows that carry a golden response are
   // checked against it; the rest go through the model.
   typedef struct {
      deq_pkg::req_type op;
      int               repeats;
      bit               golden_valid;
      deq_pkg::rsp_type golden;
   } directed_row_type;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_stall;
   deq_pkg::req_type req_data       = '0;
   logic             rsp_valid;
   logic             rsp_stall      = 1'b0;
   deq_pkg::rsp_type rsp_data;

   // Ride along with each request: the golden response, when the row has one.
   logic             req_has_golden = 1'b0;
   deq_pkg::rsp_type req_golden     = '0;

   // Model state: the ring, its front index and the fill level.
   logic [deq_pkg::DATA_W-1:0]  shadow_slots [deq_pkg::DEPTH];
   logic [deq_pkg::ADDR_W-1:0]  shadow_front = '0;
   logic [deq_pkg::COUNT_W-1:0] shadow_fill  = '0;

   deq_pkg::rsp_type pending_responses [$];
   directed_row_type directed_ops [$];

   int mismatch_count  = 0;
   int requests_taken  = 0;
   int responses_seen  = 0;
   int peak_fill       = 0;
   int idle_cycles     = 0;
   int status_tally [4] = '{0, 0, 0, 0};

   double_ended_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Apply one request to the model deque and return the response it owes.
   function automatic deq_pkg::rsp_type deque_apply(deq_pkg::req_type r);
      deq_pkg::rsp_type o;
      o = '0;
      o.status = deq_pkg::STAT_OK;
      case (r.mode)
         deq_pkg::MODE_PUSH_FRONT: begin
            if (shadow_fill == deq_pkg::COUNT_FULL) begin
               o.status = deq_pkg::STAT_FULL;
            end else begin
               // Step the front back one slot, wrapping by truncation.
               shadow_front = shadow_front - 1'b1;
               shadow_slots[shadow_front] = r.value;
               shadow_fill = shadow_fill + 1'b1;
            end
         end
         deq_pkg::MODE_PUSH_BACK: begin
            if (shadow_fill == deq_pkg::COUNT_FULL) begin
               o.status = deq_pkg::STAT_FULL;
            end else begin
               shadow_slots[shadow_front + deq_pkg::ADDR_W'(shadow_fill)] = r.value;
               shadow_fill = shadow_fill + 1'b1;
            end
         end
         deq_pkg::MODE_POP_FRONT: begin
            if (shadow_fill == '0) begin
               o.status = deq_pkg::STAT_EMPTY;
            end else begin
               o.data_out = shadow_slots[shadow_front];
               shadow_front = shadow_front + 1'b1;
               shadow_fill = shadow_fill - 1'b1;
            end
         end
         deq_pkg::MODE_POP_BACK: begin
            // Front index stays put, also when this empties the deque.
            if (shadow_fill == '0) begin
               o.status = deq_pkg::STAT_EMPTY;
            end else begin
               o.data_out =
                  shadow_slots[shadow_front + deq_pkg::ADDR_W'(shadow_fill - 1'b1)];
               shadow_fill = shadow_fill - 1'b1;
            end
         end
         deq_pkg::MODE_READ: begin
            if (deq_pkg::COUNT_W'(r.position) >= shadow_fill)
               o.status = deq_pkg::STAT_RANGE;
            else
               o.data_out = shadow_slots[shadow_front + r.position];
         end
         default: ;
      endcase
      o.entry_count = shadow_fill;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [deq_pkg::DATA_W-1:0] got,
                                  logic [deq_pkg::DATA_W-1:0] want);
      // Keep the log bounded on a badly broken design; the count still grows.
      if (mismatch_count < 200)
         $display("MISMATCH @%0t response %0d: %s got %h want %h",
                  $time, responses_seen, what, got, want);
      mismatch_count++;
   endtask

   // Words to push: mostly random, with the all-zero and all-one extremes often.
   function automatic logic [deq_pkg::DATA_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return '0;
      if (r < 24) return '1;
      return $urandom;
   endfunction

   // Sender gap: mostly none, some short, a few long.
   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Present one request and hold it until the block takes it. Returns at the
   // accepting edge, so a following request can go out back to back.
   task automatic send_request(deq_pkg::req_type r, bit has_golden,
                               deq_pkg::rsp_type golden);
      req_valid      <= 1'b1;
      req_data       <= r;
      req_has_golden <= has_golden;
      req_golden     <= golden;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Idle the sender after a request, unless this run is sent back to back.
   task automatic pace_sender(bit tight);
      int gap;
      gap = tight ? 0 : sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void add_row(logic [deq_pkg::MODE_W-1:0] mode,
                                   logic [deq_pkg::DATA_W-1:0] value,
                                   logic [deq_pkg::ADDR_W-1:0] position, int repeats,
                                   bit golden_valid, logic [deq_pkg::DATA_W-1:0] data,
                                   logic [deq_pkg::COUNT_W-1:0] count,
                                   logic [deq_pkg::STAT_W-1:0] status);
      directed_row_type row;
      row.op           = '{mode: mode, value: value, position: position};
      row.repeats      = repeats;
      row.golden_valid = golden_valid;
      row.golden       = '{data_out: data, entry_count: count, status: status};
      directed_ops.push_back(row);
   endfunction

   // Monitor: sample both handshakes at the rising edge, before anything
   // driven at that edge takes effect. Predict on request, check on response.
   always @(posedge clock) begin : monitor
      deq_pkg::rsp_type predicted;
      deq_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = deque_apply(req_data);
            pending_responses.push_back(req_has_golden ? req_golden : predicted);
            requests_taken++;
            if (int'(shadow_fill) > peak_fill) peak_fill = int'(shadow_fill);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response with no request pending", rsp_data.data_out, '0);
            end else begin
               want = pending_responses.pop_front();
               if (rsp_data.data_out !== want.data_out)
                  report_mismatch("data_out", rsp_data.data_out, want.data_out);
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", deq_pkg::DATA_W'(rsp_data.entry_count),
                                  deq_pkg::DATA_W'(want.entry_count));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", deq_pkg::DATA_W'(rsp_data.status),
                                  deq_pkg::DATA_W'(want.status));
               status_tally[want.status]++;
            end
            responses_seen++;
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses still owed",
                  idle_cycles, pending_responses.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver: alternate open stretches, choppy stalls and solid stalls.
   // Twice in the run, hold off long enough that the block fills up and
   // pushes back on the sender.
   initial begin : receiver
      int rx_cycles;
      int hold_offs;
      int pick;
      int len;
      rx_cycles = 0;
      hold_offs = 0;
      forever begin
         pick = $urandom_range(0, 99);
         if ((hold_offs == 0 && rx_cycles >= 600) ||
             (hold_offs == 1 && rx_cycles >= 2500)) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rx_cycles += HOLD_OFF_CYCLES;
            hold_offs++;
         end else if (pick < 40) begin
            len = $urandom_range(5, 40);
            rsp_stall <= 1'b0;
            repeat (len) @(posedge clock);
            rx_cycles += len;
         end else if (pick < 88) begin
            len = $urandom_range(5, 30);
            repeat (len) begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
               @(posedge clock);
            end
            rx_cycles += len;
         end else begin
            len = $urandom_range(2, 25);
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
            rx_cycles += len;
         end
      end
   end

   // Sender: reset, the directed table, random runs, then drain and verdict.
   initial begin : sender
      deq_pkg::req_type op;
      run_kind_type     kind;
      int               pick;
      int               len;
      int               random_sent;
      bit               tight;

      // Empty deque: both pops report empty, reads are out of range, and an
      // unused mode does nothing. Then one entry in and out again from the
      // other end. Then fill from the back with words stepping from zero to
      // all ones, refuse pushes at both ends while full, and drain a little.
      add_row(deq_pkg::MODE_POP_FRONT,  '0, '0, 1, 1'b1, '0, '0, deq_pkg::STAT_EMPTY);
      add_row(deq_pkg::MODE_POP_BACK,   '1, '1, 1, 1'b1, '0, '0, deq_pkg::STAT_EMPTY);
      add_row(deq_pkg::MODE_READ,       '0, '0, 1, 1'b1, '0, '0, deq_pkg::STAT_RANGE);
      add_row(deq_pkg::MODE_READ,       '1, '1, 1, 1'b1, '0, '0, deq_pkg::STAT_RANGE);
      add_row(MODE_NONE,                '1, '1, 1, 1'b1, '0, '0, deq_pkg::STAT_OK);
      add_row(deq_pkg::MODE_PUSH_FRONT, '1, '0, 1, 1'b1, '0, 5'd1, deq_pkg::STAT_OK);
      add_row(deq_pkg::MODE_READ,       '0, '0, 1, 1'b1, '1, 5'd1, deq_pkg::STAT_OK);
      add_row(deq_pkg::MODE_POP_BACK,   '0, '0, 1, 1'b1, '1, '0, deq_pkg::STAT_OK);
      add_row(deq_pkg::MODE_PUSH_BACK,  '0, '1, deq_pkg::DEPTH, 1'b0, '0, '0,
              deq_pkg::STAT_OK);
      add_row(deq_pkg::MODE_PUSH_FRONT, 32'hA5A5_A5A5, '0, 1, 1'b1, '0,
              deq_pkg::COUNT_FULL, deq_pkg::STAT_FULL);
      add_row(deq_pkg::MODE_PUSH_BACK,  32'h5A5A_5A5A, '1, 1, 1'b1, '0,
              deq_pkg::COUNT_FULL, deq_pkg::STAT_FULL);
      add_row(deq_pkg::MODE_READ,       '0, '1, 1, 1'b0, '0, '0, deq_pkg::STAT_OK);
      add_row(deq_pkg::MODE_READ,       '0, '0, 1, 1'b0, '0, '0, deq_pkg::STAT_OK);
      add_row(deq_pkg::MODE_POP_FRONT,  '0, '0, 1, 1'b0, '0, '0, deq_pkg::STAT_OK);
      add_row(deq_pkg::MODE_POP_BACK,   '0, '0, 1, 1'b0, '0, '0, deq_pkg::STAT_OK);

      // Hold reset, then release it for good.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the table; repeated rows step the word so it spans both extremes.
      foreach (directed_ops[i]) begin
         for (int k = 0; k < directed_ops[i].repeats; k++) begin
            op = directed_ops[i].op;
            op.value = op.value + deq_pkg::DATA_W'(k) * 32'h1111_1111;
            send_request(op, directed_ops[i].golden_valid, directed_ops[i].golden);
            pace_sender(1'b0);
         end
      end

      // Random runs: bursts of pushes that reach full, bursts of pops that
      // reach empty, reads at any position, and a share of pure noise.
      random_sent = 0;
      while (random_sent < RANDOM_REQUESTS) begin
         pick  = $urandom_range(0, 99);
         kind  = pick < 35 ? RUN_PUSH : pick < 65 ? RUN_POP : pick < 85 ? RUN_READ : RUN_MIXED;
         len   = $urandom_range(1, 20);
         tight = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < len; k++) begin
            op.value    = pick_word();
            op.position = deq_pkg::ADDR_W'($urandom_range(0, deq_pkg::DEPTH - 1));
            case (kind)
               RUN_PUSH:  op.mode = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_BACK
                                                         : deq_pkg::MODE_PUSH_FRONT;
               RUN_POP:   op.mode = $urandom_range(0, 1) ? deq_pkg::MODE_POP_BACK
                                                         : deq_pkg::MODE_POP_FRONT;
               RUN_READ:  op.mode = deq_pkg::MODE_READ;
               default:   op.mode = deq_pkg::MODE_W'($urandom_range(0, MODE_NONE));
            endcase
            send_request(op, 1'b0, '0);
            random_sent++;
            pace_sender(tight);
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed response, then keep watching for anything
      // unasked for.
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests, checked %0d responses, deque peaked at %0d of %0d",
               requests_taken, responses_seen, peak_fill, deq_pkg::DEPTH);
      $display("responses by status: ok %0d, empty %0d, full %0d, out of range %0d",
               status_tally[deq_pkg::STAT_OK], status_tally[deq_pkg::STAT_EMPTY],
               status_tally[deq_pkg::STAT_FULL], status_tally[deq_pkg::STAT_RANGE]);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
